// ===== rtl/ppmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types and constants for the PPM stream decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // largest accepted width or height is 2^DIM_BITS-1
  localparam int DIM_BITS = 16;
  localparam logic [16:0] DIM_MAX = 17'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [16:0] NUM_MAX = 17'd65535;
  localparam logic [16:0] NUM_SAT = 17'd65536;

  // result kinds
  localparam logic [1:0] K_COMP   = 2'd0;
  localparam logic [1:0] K_HEADER = 2'd1;
  localparam logic [1:0] K_ERROR  = 2'd2;
  localparam logic [1:0] K_DONE   = 2'd3;

  // channels
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_MAGIC   = 3'd1;
  localparam logic [2:0] E_NUMBER  = 3'd2;
  localparam logic [2:0] E_MAXVAL  = 3'd3;
  localparam logic [2:0] E_ZERO    = 3'd4;
  localparam logic [2:0] E_EARLY   = 3'd5;

  // characters
  localparam logic [7:0] C_P    = 8'h50;
  localparam logic [7:0] C_6    = 8'h36;
  localparam logic [7:0] C_3    = 8'h33;
  localparam logic [7:0] C_0    = 8'h30;
  localparam logic [7:0] C_9    = 8'h39;
  localparam logic [7:0] C_HASH = 8'h23;
  localparam logic [7:0] C_LF   = 8'h0A;
  localparam logic [7:0] C_TAB  = 8'h09;
  localparam logic [7:0] C_CR   = 8'h0D;
  localparam logic [7:0] C_SP   = 8'h20;

  // token flag bits
  localparam int TF_STARTED = 0;
  localparam int TF_BAD     = 1;
  localparam int TF_PENDING = 2;

  // parse phase
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_P6DATA = 3'd4,
    PH_P3DATA = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  // sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } seq_t;

  // one queued result (value comes from kind, channel and the divider quotient)
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] chan;
    logic [2:0] err;
  } res_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/ppm_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_stream_decoder
// Decodes a P6 or P3 PPM byte stream into header, RGBA component,
// error and completion results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: data_byte/end_of_file with in_valid, in_stall. One file
//   byte per request; end_of_file marks the last byte of a file.
//   Output channel: kind, value, channel, img_width, img_height, error_code,
//   last with out_valid, out_stall. A byte gives zero to three results;
//   last marks the final one of a byte.
//   Flow: a byte that gives no result leaves in_stall low. A byte with
//   results moves them one after another into the output register; a
//   byte that yields a component first waits for the scaling divider
//   (eight quotient bits and the hand-over). in_stall is high until all
//   results of the current byte are in the output register.
//   Reset (rst, synchronous) returns the parser to expecting the magic and
//   empties the output register. A stalled receiver holds the output
//   register and, through it, the whole block.
// ----------------------------------------------------------------------------
module ppm_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [1:0]  channel,
  output logic [15:0] img_width,
  output logic [15:0] img_height,
  output logic [2:0]  error_code,
  output logic        last
);

  ppmd_pkg::seq_t   st;
  ppmd_pkg::phase_t ph, ph_next;
  logic        ascii, ascii_next;
  logic        in_cmt, in_cmt_next;
  logic [16:0] tok_val, tok_val_next;
  logic [2:0]  tok_flg, tok_flg_next;
  logic [15:0] wid, wid_next;
  logic [15:0] hgt, hgt_next;
  logic [15:0] maxv, maxv_next;
  logic [33:0] comp_left, comp_left_next;
  logic [1:0]  chan_cnt, chan_cnt_next;

  ppmd_pkg::res_t res_next [3];
  ppmd_pkg::res_t res_q    [3];
  logic [1:0]  nres_next, nres;
  logic [1:0]  eidx;
  logic        samp;
  logic [15:0] samp_v;
  logic [15:0] res_w, res_h;
  logic        accept;
  logic        out_free;

  ppmd_pkg::div_ctl_t div_ctl;
  ppmd_pkg::div_sts_t div_sts;
  logic [23:0] div_num;
  logic [7:0]  quot;

  assign accept   = in_valid && !in_stall;
  assign in_stall = st != ppmd_pkg::S_IDLE;
  assign out_free = !out_valid || !out_stall;

  // parse step for one byte
  always_comb begin
    logic        do_end;
    logic        bad;
    logic [16:0] tv;
    logic [20:0] acc;
    logic [31:0] area;
    logic        is_space;
    ph_next        = ph;
    ascii_next     = ascii;
    in_cmt_next    = in_cmt;
    tok_val_next   = tok_val;
    tok_flg_next   = tok_flg;
    wid_next       = wid;
    hgt_next       = hgt;
    maxv_next      = maxv;
    comp_left_next = comp_left;
    chan_cnt_next  = chan_cnt;
    nres_next      = 2'd0;
    samp           = 1'b0;
    samp_v         = 16'd0;
    do_end         = 1'b0;
    bad            = 1'b0;
    tv             = 17'd0;
    acc            = 21'd0;
    area           = {16'd0, wid} * {16'd0, hgt};
    for (int i = 0; i < 3; i++) res_next[i] = '0;
    is_space = (data_byte == ppmd_pkg::C_SP) ||
               ((data_byte >= ppmd_pkg::C_TAB) && (data_byte <= ppmd_pkg::C_CR));

    // byte handling
    if (ph == ppmd_pkg::PH_P6DATA) begin
      if (maxv > 16'd255) begin
        if (tok_flg[ppmd_pkg::TF_PENDING]) begin
          tok_flg_next[ppmd_pkg::TF_PENDING] = 1'b0;
          samp         = 1'b1;
          samp_v       = {tok_val[7:0], data_byte};
          tok_val_next = 17'd0;
        end else begin
          tok_val_next = {9'd0, data_byte};
          tok_flg_next[ppmd_pkg::TF_PENDING] = 1'b1;
        end
      end else begin
        samp   = 1'b1;
        samp_v = {8'd0, data_byte};
      end
    end else if (ph != ppmd_pkg::PH_DONE && ph != ppmd_pkg::PH_ERROR) begin
      if (in_cmt) begin
        if (data_byte == ppmd_pkg::C_LF) in_cmt_next = 1'b0;
      end else if (is_space) begin
        if (tok_flg[ppmd_pkg::TF_STARTED]) do_end = 1'b1;
      end else if (!tok_flg[ppmd_pkg::TF_STARTED] && data_byte == ppmd_pkg::C_HASH) begin
        in_cmt_next = 1'b1;
      end else begin
        tok_flg_next[ppmd_pkg::TF_STARTED] = 1'b1;
        if (ph == ppmd_pkg::PH_MAGIC) begin
          if (tok_val == 17'd0) begin
            if (data_byte != ppmd_pkg::C_P) tok_flg_next[ppmd_pkg::TF_BAD] = 1'b1;
          end else if (tok_val == 17'd1) begin
            if (data_byte == ppmd_pkg::C_6) ascii_next = 1'b0;
            else if (data_byte == ppmd_pkg::C_3) ascii_next = 1'b1;
            else tok_flg_next[ppmd_pkg::TF_BAD] = 1'b1;
          end else begin
            tok_flg_next[ppmd_pkg::TF_BAD] = 1'b1;
          end
          if (tok_val < 17'd3) tok_val_next = tok_val + 17'd1;
        end else if (data_byte < ppmd_pkg::C_0 || data_byte > ppmd_pkg::C_9) begin
          tok_flg_next[ppmd_pkg::TF_BAD] = 1'b1;
        end else begin
          acc = ({4'd0, tok_val} << 3) + ({4'd0, tok_val} << 1) +
                {13'd0, 8'(data_byte - ppmd_pkg::C_0)};
          tok_val_next = (acc > 21'(ppmd_pkg::NUM_MAX)) ? ppmd_pkg::NUM_SAT : acc[16:0];
        end
      end
    end

    // end of file closes an open token
    if (end_of_file && ph != ppmd_pkg::PH_P6DATA && ph != ppmd_pkg::PH_DONE &&
        ph != ppmd_pkg::PH_ERROR && tok_flg_next[ppmd_pkg::TF_STARTED])
      do_end = 1'b1;

    // token end
    if (do_end) begin
      tv           = tok_val_next;
      bad          = tok_flg_next[ppmd_pkg::TF_BAD];
      tok_flg_next = 3'd0;
      tok_val_next = 17'd0;
      case (ph)
        ppmd_pkg::PH_MAGIC: begin
          if (bad || tv != 17'd2) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_MAGIC};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else ph_next = ppmd_pkg::PH_WIDTH;
        end
        ppmd_pkg::PH_WIDTH, ppmd_pkg::PH_HEIGHT: begin
          if (bad || tv > ppmd_pkg::NUM_MAX || tv > ppmd_pkg::DIM_MAX) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_NUMBER};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else if (ph == ppmd_pkg::PH_WIDTH) begin
            wid_next = tv[15:0];
            ph_next  = ppmd_pkg::PH_HEIGHT;
          end else begin
            hgt_next = tv[15:0];
            ph_next  = ppmd_pkg::PH_MAXVAL;
          end
        end
        ppmd_pkg::PH_MAXVAL: begin
          if (bad || tv > ppmd_pkg::NUM_MAX) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_NUMBER};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else if (tv == 17'd0) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_MAXVAL};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else if (wid == 16'd0 || hgt == 16'd0) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_ZERO};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else begin
            maxv_next      = tv[15:0];
            comp_left_next = {1'b0, area, 1'b0} + {2'd0, area};
            chan_cnt_next  = 2'd0;
            res_next[nres_next] = '{ppmd_pkg::K_HEADER, ppmd_pkg::CH_RED, ppmd_pkg::E_NONE};
            nres_next = nres_next + 2'd1;
            ph_next   = ascii ? ppmd_pkg::PH_P3DATA : ppmd_pkg::PH_P6DATA;
          end
        end
        ppmd_pkg::PH_P3DATA: begin
          if (bad || tv > ppmd_pkg::NUM_MAX) begin
            res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_NUMBER};
            nres_next = nres_next + 2'd1;
            ph_next   = ppmd_pkg::PH_ERROR;
          end else begin
            samp   = 1'b1;
            samp_v = tv[15:0];
          end
        end
        default: ;
      endcase
    end

    // component, alpha and completion
    if (samp) begin
      if (samp_v > maxv) samp_v = maxv;
      res_next[nres_next] = '{ppmd_pkg::K_COMP, chan_cnt, ppmd_pkg::E_NONE};
      nres_next = nres_next + 2'd1;
      if (chan_cnt >= ppmd_pkg::CH_BLUE) begin
        res_next[nres_next] = '{ppmd_pkg::K_COMP, ppmd_pkg::CH_ALPHA, ppmd_pkg::E_NONE};
        nres_next     = nres_next + 2'd1;
        chan_cnt_next = 2'd0;
      end else begin
        chan_cnt_next = chan_cnt + 2'd1;
      end
      if (comp_left != 34'd0) comp_left_next = comp_left - 34'd1;
      if (comp_left_next == 34'd0) begin
        res_next[nres_next] = '{ppmd_pkg::K_DONE, ppmd_pkg::CH_RED, ppmd_pkg::E_NONE};
        nres_next = nres_next + 2'd1;
        ph_next   = ppmd_pkg::PH_DONE;
      end
    end

    // file ended before the image was complete
    if (end_of_file && ph_next != ppmd_pkg::PH_DONE && ph_next != ppmd_pkg::PH_ERROR) begin
      res_next[nres_next] = '{ppmd_pkg::K_ERROR, ppmd_pkg::CH_RED, ppmd_pkg::E_EARLY};
      nres_next = nres_next + 2'd1;
      ph_next   = ppmd_pkg::PH_ERROR;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      ph        <= ppmd_pkg::PH_MAGIC;
      ascii     <= 1'b0;
      in_cmt    <= 1'b0;
      tok_val   <= 17'd0;
      tok_flg   <= 3'd0;
      wid       <= 16'd0;
      hgt       <= 16'd0;
      maxv      <= 16'd0;
      comp_left <= 34'd0;
      chan_cnt  <= 2'd0;
    end else if (accept) begin
      ph        <= ph_next;
      ascii     <= ascii_next;
      in_cmt    <= in_cmt_next;
      tok_val   <= tok_val_next;
      tok_flg   <= tok_flg_next;
      wid       <= wid_next;
      hgt       <= hgt_next;
      maxv      <= maxv_next;
      comp_left <= comp_left_next;
      chan_cnt  <= chan_cnt_next;
    end
  end

  // result list of the current request
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) res_q[i] <= res_next[i];
      nres  <= nres_next;
      res_w <= wid_next;
      res_h <= hgt_next;
    end
  end

  // scaling: v*255/maxval on the shared divider
  assign div_num   = {samp_v, 8'd0} - {8'd0, samp_v};
  assign div_ctl.start = accept && samp;

  ppmd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (maxv_next),
    .sts  (div_sts),
    .quot (quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ppmd_pkg::S_IDLE;
      eidx <= 2'd0;
    end else begin
      case (st)
        ppmd_pkg::S_IDLE: begin
          eidx <= 2'd0;
          if (accept && nres_next != 2'd0)
            st <= samp ? ppmd_pkg::S_DIV : ppmd_pkg::S_EMIT;
        end
        ppmd_pkg::S_DIV: begin
          if (div_sts.done) st <= ppmd_pkg::S_EMIT;
        end
        ppmd_pkg::S_EMIT: begin
          if (out_free) begin
            eidx <= eidx + 2'd1;
            if (eidx == nres - 2'd1) st <= ppmd_pkg::S_IDLE;
          end
        end
        default: st <= ppmd_pkg::S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (st == ppmd_pkg::S_EMIT && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ppmd_pkg::S_EMIT && out_free) begin
      kind       <= res_q[eidx].kind;
      channel    <= res_q[eidx].chan;
      error_code <= res_q[eidx].err;
      img_width  <= res_w;
      img_height <= res_h;
      last       <= eidx == nres - 2'd1;
      if (res_q[eidx].kind != ppmd_pkg::K_COMP) value <= 8'd0;
      else if (res_q[eidx].chan == ppmd_pkg::CH_ALPHA) value <= 8'd255;
      else value <= quot;
    end
  end

  // checks
  a_alpha_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ppmd_pkg::K_COMP && channel == ppmd_pkg::CH_ALPHA |-> value == 8'd255)
    else $error("alpha result not 255");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != ppmd_pkg::K_ERROR |-> error_code == ppmd_pkg::E_NONE)
    else $error("error code on non-error result");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    st == ppmd_pkg::S_EMIT |-> eidx < nres)
    else $error("result index beyond list");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    st == ppmd_pkg::S_DIV |=> st == ppmd_pkg::S_DIV || st == ppmd_pkg::S_EMIT)
    else $error("divide state left without emitting");

endmodule

// ===== rtl/ppmd_div.sv =====
// ----------------------------------------------------------------------------
// ppmd_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// The dividend must be below 256 times the divisor.
// ----------------------------------------------------------------------------
module ppmd_div (
  input  logic              clk,
  input  logic              rst,
  input  ppmd_pkg::div_ctl_t ctl,
  input  logic [23:0]       num,
  input  logic [15:0]       den,
  output ppmd_pkg::div_sts_t sts,
  output logic [7:0]        quot
);

  logic        busy;
  logic [2:0]  cnt;
  logic [15:0] rem;
  logic [7:0]  lo;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        ge;

  // one compare and subtract step
  assign trial = {rem, lo[7]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= 3'd0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= num[23:8];
      lo   <= num[7:0];
      dvs  <= den;
      quot <= 8'd0;
    end else if (busy) begin
      rem  <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      lo   <= {lo[6:0], 1'b0};
      quot <= {quot[6:0], ge};
    end
  end

endmodule
